// ----- rtl/convex_hull_monotone_chain_top_defines.svh -----
// Assertion macros shared by the hull block.
// No dependencies.
`ifndef CONVEX_HULL_MONOTONE_CHAIN_TOP_DEFINES_SVH
`define CONVEX_HULL_MONOTONE_CHAIN_TOP_DEFINES_SVH
// implication checked on every rising clock edge outside reset
`define CHM_ASSERT_IMP(label, clk, rst, a, c, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (a) |-> (c)) else $error(msg);
// next-cycle implication
`define CHM_ASSERT_NEXT(label, clk, rst, a, c, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (a) |=> (c)) else $error(msg);
`endif

// ----- rtl/chm_pkg.sv -----
// Types and constants for the monotone chain hull block.
// No dependencies.
`default_nettype none
package chm_pkg;
  localparam int CoordBits = 16;
  typedef struct packed {
    logic signed [CoordBits-1:0] point_x;
    logic signed [CoordBits-1:0] point_y;
    logic last_point;
  } in_word_t;
  typedef struct packed {
    logic signed [CoordBits-1:0] vertex_x;
    logic signed [CoordBits-1:0] vertex_y;
    logic last_vertex;
    logic no_hull;
    logic points_dropped;
  } out_word_t;
  localparam int MinHullPoints = 3;
endpackage
`default_nettype wire

// ----- rtl/chm_ram.sv -----
// Single-port-write, single-read synchronous RAM with registered read data.
// No dependencies.
`default_nettype none
module chm_ram #(
  parameter int DEPTH = 64,
  parameter int WIDTH = 32
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule
`default_nettype wire

// ----- rtl/convex_hull_monotone_chain_top.sv -----
// Top level of the monotone chain hull: store, insertion sort, chain build, emit.
// Depends on chm_pkg, chm_ram and the defines header.
//   channel | direction | payload
//   in      | in        | chm_pkg::in_word_t
//   out     | out       | chm_pkg::out_word_t
// Points load at one per cycle. On the last point, insertion sort runs, with one RAM read
// per shifted entry, O(n^2) in the worst case.
// Each chain point is fetched and pushed after its cross-product tests (two stack reads,
// multiply, compare). Emission reads each vertex from the stack before offering it.
// Reset clears counters and control; the memories need no clearing.
// Output stalls hold the emit sequencer; input is refused while a set is processed.
`default_nettype none
`include "convex_hull_monotone_chain_top_defines.svh"
module convex_hull_monotone_chain_top #(
  parameter int MAX_POINTS = 64
) (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               in_valid,
  output logic                    in_ready,
  input  wire chm_pkg::in_word_t  in_data,
  output logic                    out_valid,
  input  wire logic               out_ready,
  output chm_pkg::out_word_t      out_data
);
  localparam int CB = chm_pkg::CoordBits;
  localparam int PW = 2 * CB;
  localparam int AW = $clog2(MAX_POINTS + 1);
  localparam int SAW = $clog2(MAX_POINTS + 1);
  localparam int PAW = $clog2(MAX_POINTS);
  localparam int CW = AW + 1;

  typedef enum logic [4:0] {
    S_LOAD, S_SORT_I, S_SORT_RD, S_SORT_CMP, S_SORT_PUT,
    S_L_NEXT, S_L_RD, S_L_RDW, S_CHK_RD1, S_CHK_RD2, S_CHK_MUL, S_CHK_CMP,
    S_PUSH, S_EMIT_RD, S_EMIT_W, S_EMIT, S_NOHULL
  } state_t;
  state_t state;

  logic            ps_we;
  logic [PAW-1:0]  ps_waddr, ps_raddr;
  logic [PW-1:0]   ps_wdata, ps_rdata;
  logic            hs_we;
  logic [SAW-1:0]  hs_waddr, hs_raddr;
  logic [PW-1:0]   hs_wdata, hs_rdata;

  chm_ram #(.DEPTH(MAX_POINTS), .WIDTH(PW)) u_points (
    .clk(clk), .we(ps_we), .waddr(ps_waddr), .wdata(ps_wdata),
    .raddr(ps_raddr), .rdata(ps_rdata));
  chm_ram #(.DEPTH(MAX_POINTS + 1), .WIDTH(PW)) u_stack (
    .clk(clk), .we(hs_we), .waddr(hs_waddr), .wdata(hs_wdata),
    .raddr(hs_raddr), .rdata(hs_rdata));

  logic [CW-1:0] count, n, i, j, k, t, r, h;
  logic          overflow, dropped, upper;
  logic [PW-1:0] key, cur, a_pt, o_pt;
  logic signed [2*CB+1:0] m1, m2;

  function automatic logic after_pt(input logic [PW-1:0] a, input logic [PW-1:0] b);
    logic signed [CB-1:0] ax, ay, bx, by;
    ax = a[PW-1:CB]; ay = a[CB-1:0]; bx = b[PW-1:CB]; by = b[CB-1:0];
    if (ax != bx) return ax > bx;
    return ay > by;
  endfunction

  logic signed [CB:0] dax, day, dbx, dby;
  always_comb begin
    dax = $signed({a_pt[PW-1], a_pt[PW-1:CB]}) - $signed({o_pt[PW-1], o_pt[PW-1:CB]});
    day = $signed({a_pt[CB-1], a_pt[CB-1:0]}) - $signed({o_pt[CB-1], o_pt[CB-1:0]});
    dbx = $signed({cur[PW-1], cur[PW-1:CB]}) - $signed({o_pt[PW-1], o_pt[PW-1:CB]});
    dby = $signed({cur[CB-1], cur[CB-1:0]}) - $signed({o_pt[CB-1], o_pt[CB-1:0]});
  end

  assign in_ready = (state == S_LOAD);
  wire in_acc = in_valid && in_ready;
  wire out_acc = out_valid && out_ready;

  always_comb begin
    ps_we = 1'b0; ps_waddr = count[PAW-1:0]; ps_wdata = {in_data.point_x, in_data.point_y};
    ps_raddr = j[PAW-1:0];
    hs_we = 1'b0; hs_waddr = k[SAW-1:0]; hs_wdata = cur; hs_raddr = k[SAW-1:0];
    case (state)
      S_LOAD: ps_we = in_acc && (count < CW'(MAX_POINTS));
      S_SORT_I: ps_raddr = i[PAW-1:0];
      S_SORT_RD: ps_raddr = PAW'(j - 1'b1);
      S_SORT_CMP: begin
        if (after_pt(ps_rdata, key)) begin
          ps_we = 1'b1; ps_waddr = j[PAW-1:0]; ps_wdata = ps_rdata;
        end
      end
      S_SORT_PUT: begin
        ps_we = 1'b1; ps_waddr = j[PAW-1:0]; ps_wdata = key;
      end
      S_L_NEXT: ps_raddr = i[PAW-1:0];
      S_CHK_RD1: hs_raddr = SAW'(k - 2'd2);
      S_CHK_RD2: hs_raddr = SAW'(k - 1'b1);
      S_PUSH: hs_we = (k < CW'(MAX_POINTS + 1));
      S_EMIT_RD: hs_raddr = r[SAW-1:0];
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_LOAD; count <= '0; overflow <= 1'b0; out_valid <= 1'b0;
    end else begin
      case (state)
        S_LOAD: begin
          if (in_acc) begin
            if (in_data.last_point) begin
              n <= (count < CW'(MAX_POINTS)) ? count + 1'b1 : count;
              dropped <= overflow || !(count < CW'(MAX_POINTS));
              count <= '0; overflow <= 1'b0;
              i <= CW'(1);
              if (((count < CW'(MAX_POINTS)) ? count + 1'b1 : count) <
                  CW'(chm_pkg::MinHullPoints)) state <= S_NOHULL;
              else state <= S_SORT_I;
            end else begin
              if (count < CW'(MAX_POINTS)) count <= count + 1'b1;
              else overflow <= 1'b1;
            end
          end
        end
        S_SORT_I: begin
          if (i >= n) begin
            i <= '0; k <= '0; upper <= 1'b0; state <= S_L_NEXT;
          end else begin
            j <= i; state <= S_SORT_RD;
          end
        end
        S_SORT_RD: begin
          if (j == i) key <= ps_rdata;
          state <= (j == '0) ? S_SORT_PUT : S_SORT_CMP;
        end
        S_SORT_CMP: begin
          if (after_pt(ps_rdata, key)) begin
            j <= j - 1'b1; state <= S_SORT_RD;
          end else begin
            state <= S_SORT_PUT;
          end
        end
        S_SORT_PUT: begin
          i <= i + 1'b1; state <= S_SORT_I;
        end
        S_L_NEXT: state <= S_L_RD;
        S_L_RD: begin
          cur <= ps_rdata; state <= S_L_RDW;
        end
        S_L_RDW: begin
          if ((!upper && k >= CW'(2)) || (upper && k >= t)) state <= S_CHK_RD1;
          else state <= S_PUSH;
        end
        S_CHK_RD1: state <= S_CHK_RD2;
        S_CHK_RD2: begin
          o_pt <= hs_rdata; state <= S_CHK_MUL;
        end
        S_CHK_MUL: begin
          a_pt <= hs_rdata; state <= S_CHK_CMP;
        end
        S_CHK_CMP: begin
          m1 <= dax * dby; m2 <= day * dbx;
          state <= S_EMIT_W;
        end
        S_EMIT_W: begin
          if (m1 <= m2) begin
            k <= k - 1'b1; state <= S_L_RDW;
          end else begin
            state <= S_PUSH;
          end
        end
        S_PUSH: begin
          if (k < CW'(MAX_POINTS + 1)) k <= k + 1'b1;
          if (!upper) begin
            if (i + 1'b1 >= n) begin
              upper <= 1'b1;
              t <= ((k < CW'(MAX_POINTS + 1)) ? k + 1'b1 : k) + 1'b1;
              i <= n - 2'd2; state <= S_L_NEXT;
            end else begin
              i <= i + 1'b1; state <= S_L_NEXT;
            end
          end else if (i == '0) begin
            h <= ((k < CW'(MAX_POINTS + 1)) ? k + 1'b1 : k) - 1'b1;
            r <= '0; state <= S_EMIT_RD;
          end else begin
            i <= i - 1'b1; state <= S_L_NEXT;
          end
        end
        S_EMIT_RD: state <= S_EMIT;
        S_EMIT: begin
          if (!out_valid) begin
            out_valid <= 1'b1;
            out_data.vertex_x <= hs_rdata[PW-1:CB];
            out_data.vertex_y <= hs_rdata[CB-1:0];
            out_data.last_vertex <= (r + 1'b1 == h);
            out_data.no_hull <= 1'b0;
            out_data.points_dropped <= dropped;
          end else if (out_ready) begin
            out_valid <= 1'b0;
            if (r + 1'b1 == h) state <= S_LOAD;
            else begin
              r <= r + 1'b1; state <= S_EMIT_RD;
            end
          end
        end
        S_NOHULL: begin
          if (!out_valid) begin
            out_valid <= 1'b1;
            out_data.vertex_x <= '0; out_data.vertex_y <= '0;
            out_data.last_vertex <= 1'b1; out_data.no_hull <= 1'b1;
            out_data.points_dropped <= dropped;
          end else if (out_ready) begin
            out_valid <= 1'b0; state <= S_LOAD;
          end
        end
        default: state <= S_LOAD;
      endcase
    end
  end

  `CHM_ASSERT_IMP(a_ready_only_load, clk, rst, in_ready, !out_valid, "ready with pending word")
  `CHM_ASSERT_NEXT(a_out_hold, clk, rst, out_valid && !out_ready, out_valid && $stable(out_data), "output word changed while stalled")
  `CHM_ASSERT_IMP(a_count_range, clk, rst, 1'b1, count <= CW'(MAX_POINTS), "point count beyond capacity")
endmodule
`default_nettype wire

// ----- verif/convex_hull_monotone_chain_top_tb.sv -----
// Testbench for the monotone chain hull block: sends point sets, predicts the
// hull vertices internally and checks every emitted word under random idling.
// Depends on chm_pkg and convex_hull_monotone_chain_top.
`timescale 1ns / 1ps
module convex_hull_monotone_chain_top_tb;

  localparam int StoreDepth = 64;
  localparam int CB = chm_pkg::CoordBits;

  class hull_scoreboard;
    chm_pkg::out_word_t vertex_q[$];
    longint px[StoreDepth];
    longint py[StoreDepth];
    int unsigned stored;
    bit dropped;
    int errors;
    int vertices_seen;
    int sets_closed;

    function bit not_left(longint ox, longint oy, longint ax, longint ay,
                          longint bx, longint by);
      return (ax - ox) * (by - oy) <= (ay - oy) * (bx - ox);
    endfunction

    function void note_point(chm_pkg::in_word_t w);
      longint sx[StoreDepth + 1];
      longint sy[StoreDepth + 1];
      longint kx, ky;
      int n, k, t, i, j, h;
      chm_pkg::out_word_t v;
      if (stored < StoreDepth) begin
        px[stored] = longint'(w.point_x);
        py[stored] = longint'(w.point_y);
        stored++;
      end else begin
        dropped = 1'b1;
      end
      if (!w.last_point) return;
      n = stored;
      sets_closed++;
      if (n < chm_pkg::MinHullPoints) begin
        v = '0;
        v.last_vertex = 1'b1;
        v.no_hull = 1'b1;
        v.points_dropped = dropped;
        vertex_q.push_back(v);
      end else begin
        for (i = 1; i < n; i++) begin
          kx = px[i];
          ky = py[i];
          j = i;
          while (j > 0 && (px[j-1] > kx || (px[j-1] == kx && py[j-1] > ky))) begin
            px[j] = px[j-1];
            py[j] = py[j-1];
            j--;
          end
          px[j] = kx;
          py[j] = ky;
        end
        k = 0;
        for (i = 0; i < n; i++) begin
          while (k >= 2 && not_left(sx[k-2], sy[k-2], sx[k-1], sy[k-1], px[i], py[i]))
            k--;
          if (k < StoreDepth + 1) begin
            sx[k] = px[i];
            sy[k] = py[i];
            k++;
          end
        end
        t = k + 1;
        for (i = n - 2; i >= 0; i--) begin
          while (k >= t && not_left(sx[k-2], sy[k-2], sx[k-1], sy[k-1], px[i], py[i]))
            k--;
          if (k < StoreDepth + 1) begin
            sx[k] = px[i];
            sy[k] = py[i];
            k++;
          end
        end
        h = k - 1;
        for (i = 0; i < h; i++) begin
          v.vertex_x = sx[i][CB-1:0];
          v.vertex_y = sy[i][CB-1:0];
          v.last_vertex = (i + 1 == h);
          v.no_hull = 1'b0;
          v.points_dropped = dropped;
          vertex_q.push_back(v);
        end
      end
      stored = 0;
      dropped = 1'b0;
    endfunction

    function void check_vertex(chm_pkg::out_word_t got);
      chm_pkg::out_word_t exp;
      vertices_seen++;
      if (vertex_q.size() == 0) begin
        $display("%0t: unexpected vertex word %h", $time, got);
        errors++;
        return;
      end
      exp = vertex_q.pop_front();
      if (got.vertex_x !== exp.vertex_x || got.vertex_y !== exp.vertex_y ||
          got.last_vertex !== exp.last_vertex || got.no_hull !== exp.no_hull ||
          got.points_dropped !== exp.points_dropped) begin
        $display("%0t: vertex mismatch: expected x=%0d y=%0d last=%b nohull=%b drop=%b",
                 $time, exp.vertex_x, exp.vertex_y, exp.last_vertex, exp.no_hull,
                 exp.points_dropped);
        $display("%0t:                  actual x=%0d y=%0d last=%b nohull=%b drop=%b",
                 $time, got.vertex_x, got.vertex_y, got.last_vertex, got.no_hull,
                 got.points_dropped);
        errors++;
      end
    endfunction
  endclass

  logic clk;
  logic rst;
  logic in_valid;
  logic in_ready;
  chm_pkg::in_word_t in_data;
  logic out_valid;
  logic out_ready = 1'b0;
  chm_pkg::out_word_t out_data;

  hull_scoreboard sb;
  int tx_idle;
  int rx_idle;
  int hold_cnt = 0;
  bit hold_req = 1'b0;
  bit hold_done = 1'b0;
  int points_sent;
  int wait_cnt;

  convex_hull_monotone_chain_top dut (
    .clk(clk),
    .rst(rst),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .in_data(in_data),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_data(out_data)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  initial begin
    #2000000;
    $display("convex_hull_monotone_chain_top_tb: done, errors");
    $finish;
  end

  // receiver: random stalls, or one long hold-off when asked
  always @(posedge clk) begin
    if (hold_cnt > 0) begin
      hold_cnt <= hold_cnt - 1;
      out_ready <= 1'b0;
    end else if (hold_req && !hold_done) begin
      hold_done <= 1'b1;
      hold_cnt <= 2000;
      out_ready <= 1'b0;
    end else begin
      out_ready <= ($urandom_range(99) >= rx_idle);
    end
  end

  always @(posedge clk) begin
    if (!rst && out_valid && out_ready) sb.check_vertex(out_data);
  end

  task automatic send_point(logic signed [CB-1:0] x,
                            logic signed [CB-1:0] y, bit last);
    chm_pkg::in_word_t w;
    w.point_x = x;
    w.point_y = y;
    w.last_point = last;
    while ($urandom_range(99) < tx_idle) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data <= w;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    sb.note_point(w);
    points_sent++;
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    wait_cnt = 0;
    while (sb.vertex_q.size() != 0 && wait_cnt < 200000) begin
      @(posedge clk);
      wait_cnt++;
    end
  endtask

  // mode 0: full range, 1: tight grid (duplicates, collinear), 2: extremes
  task automatic random_set(int n, int mode);
    logic signed [CB-1:0] x, y;
    for (int i = 0; i < n; i++) begin
      case (mode)
        0: begin
          x = CB'($urandom);
          y = CB'($urandom);
        end
        1: begin
          x = CB'($urandom_range(6)) - 16'd3;
          y = CB'($urandom_range(6)) - 16'd3;
        end
        default: begin
          x = $urandom_range(1) ? 16'sh7fff : 16'sh8000;
          y = $urandom_range(2) == 0 ? 16'sh0000 : ($urandom_range(1) ? 16'sh7fff : 16'sh8000);
        end
      endcase
      send_point(x, y, i == n - 1);
    end
  endtask

  initial begin
    sb = new();
    rst = 1'b1;
    in_valid = 1'b0;
    in_data = '0;
    tx_idle = 0;
    rx_idle = 0;
    points_sent = 0;
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed sets: too few points, collinear, all equal, extremes, clockwise order
    send_point(16'sh7fff, 16'sh8000, 1);
    send_point(16'sh0001, 16'sh0002, 0);
    send_point(16'sh0003, 16'sh0004, 1);
    send_point(16'sh8000, 16'sh8000, 0);
    send_point(16'sh0000, 16'sh0000, 0);
    send_point(16'sh7fff, 16'sh7fff, 1);
    repeat (3) send_point(16'sh0005, -16'sh0007, 0);
    send_point(16'sh0005, -16'sh0007, 1);
    send_point(16'sh8000, 16'sh8000, 0);
    send_point(16'sh7fff, 16'sh8000, 0);
    send_point(16'sh0000, 16'sh0000, 0);
    send_point(16'sh7fff, 16'sh7fff, 0);
    send_point(16'sh8000, 16'sh7fff, 1);
    send_point(16'sh0000, 16'sh000a, 0);
    send_point(16'sh000a, 16'sh0000, 0);
    send_point(16'sh0000, 16'sh0000, 1);
    drain();

    // store overflow, closing point itself discarded
    random_set(StoreDepth + 1, 0);
    drain();

    tx_idle = 29;
    rx_idle = 75;
    while (points_sent < 105) random_set($urandom_range(12, 1), $urandom_range(2));
    drain();

    tx_idle = 75;
    rx_idle = 29;
    while (points_sent < 130) random_set($urandom_range(12, 1), $urandom_range(2));
    drain();

    tx_idle = 0;
    rx_idle = 0;
    hold_req <= 1'b1;
    random_set(10, 0);
    random_set(8, 1);
    while (points_sent < 180) random_set($urandom_range(12, 1), $urandom_range(2));
    drain();
    repeat (200) @(posedge clk);

    $display("sent %0d points in %0d sets, checked %0d vertex words",
             points_sent, sb.sets_closed, sb.vertices_seen);
    if (sb.errors == 0 && sb.vertex_q.size() == 0) begin
      $display("convex_hull_monotone_chain_top_tb: done, clean");
    end else begin
      if (sb.vertex_q.size() != 0)
        $display("%0t: %0d expected vertex words never arrived", $time, sb.vertex_q.size());
      $display("convex_hull_monotone_chain_top_tb: done, errors");
    end
    $finish;
  end
endmodule

// ----- sim.f -----
+incdir+rtl
rtl/chm_pkg.sv
rtl/chm_ram.sv
rtl/convex_hull_monotone_chain_top.sv
verif/convex_hull_monotone_chain_top_tb.sv
